>>> rtl/gtdl_pkg.sv
// Shared constants, types and codes for the GPS track delta logger.
`timescale 1ns / 1ps

package gtdl_pkg;

    localparam int MAX_RECORDS  = 512;
    localparam int POS_SHIFT    = 5;
    localparam int HEIGHT_SHIFT = 5;

    localparam int COORD_W   = 32;
    localparam int POS_W     = COORD_W - POS_SHIFT;
    localparam int ALT_W     = 16;
    localparam int ALT_OUT_W = ALT_W + HEIGHT_SHIFT;
    localparam int HDG_W     = 9;
    localparam int RN_W      = 9;
    localparam int DELTA_W   = 8;
    localparam int REC_W     = 4 * DELTA_W;
    localparam int ADDR_W    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_RECORDS + 1);
    localparam int MODE_W    = 2;
    localparam int OP_W      = 2;

    localparam int DELTA_MIN = -128;
    localparam int DELTA_MAX = 127;

    localparam logic [MODE_W-1:0] MODE_TRACK_LOGGER = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_START_LOG    = 2'd0,
        OP_LOG_SAMPLE   = 2'd1,
        OP_START_REPLAY = 2'd2,
        OP_REPLAY_NEXT  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

>>> rtl/gtdl_ctrl.sv
// Controller state machine for the GPS track delta logger.
`timescale 1ns / 1ps

module gtdl_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output gtdl_pkg::cmd_t cmd
);

    gtdl_pkg::state_t state_reg;
    gtdl_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtdl_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            gtdl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = gtdl_pkg::ST_EXEC;
                end
            end
            gtdl_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
                done_next   = 1'b1;
                state_next  = gtdl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gtdl_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == gtdl_pkg::ST_EXEC);
    assign done = done_reg;

endmodule

>>> rtl/gtdl_datapath.sv
// Datapath of the GPS track delta logger: record store, accumulators and result registers.
`timescale 1ns / 1ps

module gtdl_datapath
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  gtdl_pkg::cmd_t                          cmd,
    input  logic                                    cfg_we,
    input  logic [gtdl_pkg::MODE_W-1:0]             cfg_wdata,
    input  logic [gtdl_pkg::OP_W-1:0]               operation,
    input  logic signed [gtdl_pkg::COORD_W-1:0]     lat_in,
    input  logic signed [gtdl_pkg::COORD_W-1:0]     lon_in,
    input  logic signed [gtdl_pkg::COORD_W-1:0]     alt_in,
    input  logic signed [gtdl_pkg::HDG_W-1:0]       heading_in,
    input  logic                                    gps_fix,
    input  logic                                    armed,
    input  logic                                    alt_ready,
    output logic                                    accepted,
    output logic [gtdl_pkg::RN_W-1:0]               record_number,
    output logic signed [gtdl_pkg::COORD_W-1:0]     lat_out,
    output logic signed [gtdl_pkg::COORD_W-1:0]     lon_out,
    output logic signed [gtdl_pkg::ALT_OUT_W-1:0]   alt_out,
    output logic signed [gtdl_pkg::HDG_W-1:0]       heading_out
);

    localparam int POS_W   = gtdl_pkg::POS_W;
    localparam int ALT_W   = gtdl_pkg::ALT_W;
    localparam int CNT_W   = gtdl_pkg::CNT_W;
    localparam int ADDR_W  = gtdl_pkg::ADDR_W;
    localparam int DELTA_W = gtdl_pkg::DELTA_W;
    localparam int REC_W   = gtdl_pkg::REC_W;
    localparam int COORD_W = gtdl_pkg::COORD_W;

    // Record store; entries are only used below the record count.
    logic [REC_W-1:0] mem [gtdl_pkg::MAX_RECORDS];
    logic [REC_W-1:0] rd_data_reg;

    // Captured transaction.
    gtdl_pkg::op_t                 op_reg;
    logic signed [COORD_W-1:0]     lat_reg;
    logic signed [COORD_W-1:0]     lon_reg;
    logic signed [COORD_W-1:0]     alt_reg;
    logic signed [gtdl_pkg::HDG_W-1:0] hdg_reg;
    logic                          fix_reg;
    logic                          arm_reg;
    logic                          ardy_reg;

    // Configuration and architectural state.
    logic [gtdl_pkg::MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            ptr_reg, ptr_next;
    logic signed [POS_W-1:0]     prev_lat_reg, prev_lat_next;
    logic signed [POS_W-1:0]     prev_lon_reg, prev_lon_next;
    logic signed [ALT_W-1:0]     prev_alt_reg, prev_alt_next;
    logic signed [POS_W-1:0]     base_lat_reg, base_lat_next;
    logic signed [POS_W-1:0]     base_lon_reg, base_lon_next;
    logic signed [ALT_W-1:0]     base_alt_reg, base_alt_next;

    // Result registers.
    logic                                  acc_reg, acc_next;
    logic [gtdl_pkg::RN_W-1:0]             rn_reg, rn_next;
    logic signed [COORD_W-1:0]             lat_o_reg, lat_o_next;
    logic signed [COORD_W-1:0]             lon_o_reg, lon_o_next;
    logic signed [gtdl_pkg::ALT_OUT_W-1:0] alt_o_reg, alt_o_next;
    logic signed [gtdl_pkg::HDG_W-1:0]     hdg_o_reg, hdg_o_next;

    // Combinational datapath values.
    logic signed [POS_W-1:0] red_lat;
    logic signed [POS_W-1:0] red_lon;
    logic signed [ALT_W-1:0] red_alt;
    logic signed [POS_W:0]   dlat;
    logic signed [POS_W:0]   dlon;
    logic signed [ALT_W:0]   dalt;
    logic [REC_W-1:0]        wr_word;
    logic                    wr_en;
    logic signed [POS_W-1:0] sum_lat;
    logic signed [POS_W-1:0] sum_lon;
    logic signed [ALT_W-1:0] sum_alt;

    function automatic logic [DELTA_W-1:0] clamp_delta(input logic signed [POS_W:0] d);
        logic [DELTA_W-1:0] r;
        if (d < gtdl_pkg::DELTA_MIN)
            r = DELTA_W'(gtdl_pkg::DELTA_MIN);
        else if (d > gtdl_pkg::DELTA_MAX)
            r = DELTA_W'(gtdl_pkg::DELTA_MAX);
        else
            r = d[DELTA_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= wr_word;
        end
        if (cmd.capture)
        begin
            op_reg   <= gtdl_pkg::op_t'(operation);
            lat_reg  <= lat_in;
            lon_reg  <= lon_in;
            alt_reg  <= alt_in;
            hdg_reg  <= heading_in;
            fix_reg  <= gps_fix;
            arm_reg  <= armed;
            ardy_reg <= alt_ready;
        end
        if (cmd.execute)
        begin
            rn_reg    <= rn_next;
            lat_o_reg <= lat_o_next;
            lon_o_reg <= lon_o_next;
            alt_o_reg <= alt_o_next;
            hdg_o_reg <= hdg_o_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            count_reg    <= '0;
            ptr_reg      <= '0;
            prev_lat_reg <= '0;
            prev_lon_reg <= '0;
            prev_alt_reg <= '0;
            base_lat_reg <= '0;
            base_lon_reg <= '0;
            base_alt_reg <= '0;
            acc_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.execute)
            begin
                count_reg    <= count_next;
                ptr_reg      <= ptr_next;
                prev_lat_reg <= prev_lat_next;
                prev_lon_reg <= prev_lon_next;
                prev_alt_reg <= prev_alt_next;
                base_lat_reg <= base_lat_next;
                base_lon_reg <= base_lon_next;
                base_alt_reg <= base_alt_next;
                acc_reg      <= acc_next;
            end
        end
    end

    always_comb
    begin
        red_lat = lat_reg[COORD_W-1:gtdl_pkg::POS_SHIFT];
        red_lon = lon_reg[COORD_W-1:gtdl_pkg::POS_SHIFT];
        red_alt = alt_reg[gtdl_pkg::HEIGHT_SHIFT +: ALT_W];

        dlat = (POS_W+1)'(red_lat) - (POS_W+1)'(prev_lat_reg);
        dlon = (POS_W+1)'(red_lon) - (POS_W+1)'(prev_lon_reg);
        dalt = (ALT_W+1)'(red_alt) - (ALT_W+1)'(prev_alt_reg);

        wr_word = {hdg_reg[gtdl_pkg::HDG_W-1:1],
                   clamp_delta((POS_W+1)'(dalt)),
                   clamp_delta(dlon),
                   clamp_delta(dlat)};

        sum_lat = prev_lat_reg + POS_W'($signed(rd_data_reg[DELTA_W-1:0]));
        sum_lon = prev_lon_reg + POS_W'($signed(rd_data_reg[2*DELTA_W-1:DELTA_W]));
        sum_alt = prev_alt_reg + ALT_W'($signed(rd_data_reg[3*DELTA_W-1:2*DELTA_W]));

        wr_en         = 1'b0;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        prev_lat_next = prev_lat_reg;
        prev_lon_next = prev_lon_reg;
        prev_alt_next = prev_alt_reg;
        base_lat_next = base_lat_reg;
        base_lon_next = base_lon_reg;
        base_alt_next = base_alt_reg;
        acc_next      = 1'b0;
        rn_next       = '0;
        lat_o_next    = '0;
        lon_o_next    = '0;
        alt_o_next    = '0;
        hdg_o_next    = '0;

        if (mode_reg == gtdl_pkg::MODE_TRACK_LOGGER)
        begin
            case (op_reg)
                gtdl_pkg::OP_START_LOG:
                begin
                    count_next = '0;
                    if (fix_reg && arm_reg && ardy_reg)
                    begin
                        prev_lat_next = red_lat;
                        prev_lon_next = red_lon;
                        prev_alt_next = red_alt;
                        base_lat_next = red_lat;
                        base_lon_next = red_lon;
                        base_alt_next = red_alt;
                        acc_next      = 1'b1;
                    end
                end
                gtdl_pkg::OP_LOG_SAMPLE:
                begin
                    if (fix_reg && arm_reg && (count_reg < CNT_W'(gtdl_pkg::MAX_RECORDS)))
                    begin
                        wr_en         = cmd.execute;
                        prev_lat_next = red_lat;
                        prev_lon_next = red_lon;
                        prev_alt_next = red_alt;
                        count_next    = count_reg + CNT_W'(1);
                        acc_next      = 1'b1;
                    end
                end
                gtdl_pkg::OP_START_REPLAY:
                begin
                    if (count_reg != '0)
                    begin
                        prev_lat_next = base_lat_reg;
                        prev_lon_next = base_lon_reg;
                        prev_alt_next = base_alt_reg;
                        ptr_next      = '0;
                        acc_next      = 1'b1;
                    end
                end
                gtdl_pkg::OP_REPLAY_NEXT:
                begin
                    if ((ptr_reg < count_reg) && (ptr_reg < CNT_W'(gtdl_pkg::MAX_RECORDS)))
                    begin
                        prev_lat_next = sum_lat;
                        prev_lon_next = sum_lon;
                        prev_alt_next = sum_alt;
                        rn_next       = gtdl_pkg::RN_W'(ptr_reg);
                        lat_o_next    = COORD_W'(sum_lat) <<< gtdl_pkg::POS_SHIFT;
                        lon_o_next    = COORD_W'(sum_lon) <<< gtdl_pkg::POS_SHIFT;
                        alt_o_next    = gtdl_pkg::ALT_OUT_W'(sum_alt) <<< gtdl_pkg::HEIGHT_SHIFT;
                        hdg_o_next    = {rd_data_reg[REC_W-1:3*DELTA_W], 1'b0};
                        ptr_next      = ptr_reg + CNT_W'(1);
                        acc_next      = 1'b1;
                    end
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    assign accepted      = acc_reg;
    assign record_number = rn_reg;
    assign lat_out       = lat_o_reg;
    assign lon_out       = lon_o_reg;
    assign alt_out       = alt_o_reg;
    assign heading_out   = hdg_o_reg;

endmodule

>>> rtl/gps_track_delta_logger.sv
// Top level of the GPS track delta logger: controller plus datapath.
`timescale 1ns / 1ps
// A transaction accepted at a clock edge is captured, then executed in the execute state;
// its result is then registered onto the outputs with done high; the receiver cannot stall it.
// No new transaction is taken until the current one has been executed; busy is high during
// the execute state.
// Reset: rst_n is asynchronous and active low; it clears the mode, record count, replay
// pointer and all accumulators. The record store is not cleared and needs no clearing pass.

module gps_track_delta_logger
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Command channel.
    input  logic                                    start,
    output logic                                    busy,
    input  logic [gtdl_pkg::OP_W-1:0]               operation,
    input  logic signed [gtdl_pkg::COORD_W-1:0]     lat_in,
    input  logic signed [gtdl_pkg::COORD_W-1:0]     lon_in,
    input  logic signed [gtdl_pkg::COORD_W-1:0]     alt_in,
    input  logic signed [gtdl_pkg::HDG_W-1:0]       heading_in,
    input  logic                                    gps_fix,
    input  logic                                    armed,
    input  logic                                    alt_ready,
    // Configuration write port for the log mode register.
    input  logic                                    cfg_we,
    input  logic [gtdl_pkg::MODE_W-1:0]             cfg_wdata,
    // Result channel; done marks a result for exactly one cycle.
    output logic                                    done,
    output logic                                    accepted,
    output logic [gtdl_pkg::RN_W-1:0]               record_number,
    output logic signed [gtdl_pkg::COORD_W-1:0]     lat_out,
    output logic signed [gtdl_pkg::COORD_W-1:0]     lon_out,
    output logic signed [gtdl_pkg::ALT_OUT_W-1:0]   alt_out,
    output logic signed [gtdl_pkg::HDG_W-1:0]       heading_out
);

    // The controller captures a transaction when start arrives in the idle state, then
    // executes it in the execute state. The datapath reads the record at the replay pointer
    // on every clock, so the record is ready by the execute cycle.
    gtdl_pkg::cmd_t cmd;

    gtdl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the record store, the base and running accumulators, and the
    // result registers, which are loaded at the end of the execute cycle.
    gtdl_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .operation     (operation),
        .lat_in        (lat_in),
        .lon_in        (lon_in),
        .alt_in        (alt_in),
        .heading_in    (heading_in),
        .gps_fix       (gps_fix),
        .armed         (armed),
        .alt_ready     (alt_ready),
        .accepted      (accepted),
        .record_number (record_number),
        .lat_out       (lat_out),
        .lon_out       (lon_out),
        .alt_out       (alt_out),
        .heading_out   (heading_out)
    );

endmodule

>>> tb/sv/gps_track_delta_logger_test.sv
// Self-checking testbench for the GPS track delta logger with a live track model.
`timescale 1ns / 1ps

module gps_track_delta_logger_test;

    import gtdl_pkg::*;

    // Generous ceiling: the slowest correct run stays well under it.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;

    // Mode register values other than the track logger; all of them disable the block.
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TOP   = 2'd3;

    // One command transaction as it is presented on the input ports.
    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] lat;
        logic [COORD_W-1:0] lon;
        logic [COORD_W-1:0] alt;
        logic [HDG_W-1:0]   heading;
        logic               fix;
        logic               arm;
        logic               ready;
    } track_cmd_t;

    // One result transaction as it appears on the output ports while done is high.
    typedef struct packed {
        logic                 accepted;
        logic [RN_W-1:0]      record_number;
        logic [COORD_W-1:0]   lat_out;
        logic [COORD_W-1:0]   lon_out;
        logic [ALT_OUT_W-1:0] alt_out;
        logic [HDG_W-1:0]     heading_out;
    } track_result_t;

    // Every input of the block starts at a known value before reset is even applied.
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       operation  = '0;
    logic signed [COORD_W-1:0] lat_in = '0;
    logic signed [COORD_W-1:0] lon_in = '0;
    logic signed [COORD_W-1:0] alt_in = '0;
    logic signed [HDG_W-1:0] heading_in = '0;
    logic                  gps_fix    = 1'b0;
    logic                  armed      = 1'b0;
    logic                  alt_ready  = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [MODE_W-1:0]     cfg_wdata  = '0;
    logic                  done;
    logic                  accepted;
    logic [RN_W-1:0]       record_number;
    logic signed [COORD_W-1:0] lat_out;
    logic signed [COORD_W-1:0] lon_out;
    logic signed [ALT_OUT_W-1:0] alt_out;
    logic signed [HDG_W-1:0] heading_out;

    // Stimulus backlog, the command currently on the bus, and the results still owed.
    track_cmd_t    cmd_backlog [$];
    track_cmd_t    on_bus;
    track_cmd_t    next_cmd;
    track_result_t due_results [$];
    track_result_t seen;
    track_result_t want;
    string         bad_fields;

    int          queued_count    = 0;
    int          sent_count      = 0;
    int          fail_count      = 0;
    int          cycle_count     = 0;
    int unsigned sender_idle_pct = 0;

    // Shadow copy of the logger state, advanced once per accepted command.
    logic [MODE_W-1:0]       mode_shadow = '0;
    logic [REC_W-1:0]        rec_mem [MAX_RECORDS];
    int                      rec_count   = 0;
    int                      replay_ptr  = 0;
    logic signed [POS_W-1:0] prev_lat    = '0;
    logic signed [POS_W-1:0] prev_lon    = '0;
    logic signed [POS_W-1:0] base_lat    = '0;
    logic signed [POS_W-1:0] base_lon    = '0;
    logic signed [ALT_W-1:0] prev_alt    = '0;
    logic signed [ALT_W-1:0] base_alt    = '0;

    gps_track_delta_logger dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .lat_in        (lat_in),
        .lon_in        (lon_in),
        .alt_in        (alt_in),
        .heading_in    (heading_in),
        .gps_fix       (gps_fix),
        .armed         (armed),
        .alt_ready     (alt_ready),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .accepted      (accepted),
        .record_number (record_number),
        .lat_out       (lat_out),
        .lon_out       (lon_out),
        .alt_out       (alt_out),
        .heading_out   (heading_out)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A stored delta is the difference of two reduced values, pinned to the signed byte range.
    function automatic logic [DELTA_W-1:0] clamp_delta(longint diff);
        if (diff < DELTA_MIN)
            return DELTA_W'(DELTA_MIN);
        if (diff > DELTA_MAX)
            return DELTA_W'(DELTA_MAX);
        return DELTA_W'(diff);
    endfunction

    // Applies one accepted command to the shadow state and returns the result it must produce.
    // Refused commands and everything but an accepted replay_next carry zero data fields.
    function automatic track_result_t step_track_model(track_cmd_t c);
        track_result_t             r;
        logic signed [POS_W-1:0]   new_lat;
        logic signed [POS_W-1:0]   new_lon;
        logic signed [ALT_W-1:0]   new_alt;
        logic [REC_W-1:0]          word;
        logic signed [DELTA_W-1:0] d_lat;
        logic signed [DELTA_W-1:0] d_lon;
        logic signed [DELTA_W-1:0] d_alt;
        r = '0;
        if (mode_shadow != MODE_TRACK_LOGGER)
            return r;
        // Reduced coordinates drop the low bits; altitude keeps only 16 bits above them.
        new_lat = c.lat[COORD_W-1:POS_SHIFT];
        new_lon = c.lon[COORD_W-1:POS_SHIFT];
        new_alt = c.alt[ALT_W+HEIGHT_SHIFT-1:HEIGHT_SHIFT];
        case (c.op)
            OP_START_LOG:
            begin
                // The count is cleared even when the base cannot be latched.
                rec_count = 0;
                if (c.fix && c.arm && c.ready)
                begin
                    prev_lat   = new_lat;
                    prev_lon   = new_lon;
                    prev_alt   = new_alt;
                    base_lat   = new_lat;
                    base_lon   = new_lon;
                    base_alt   = new_alt;
                    r.accepted = 1'b1;
                end
            end
            OP_LOG_SAMPLE:
            begin
                // Logging ignores the altitude reference flag.
                if (c.fix && c.arm && rec_count < MAX_RECORDS)
                begin
                    rec_mem[rec_count] = {c.heading[HDG_W-1:1],
                                          clamp_delta(longint'(new_alt) - longint'(prev_alt)),
                                          clamp_delta(longint'(new_lon) - longint'(prev_lon)),
                                          clamp_delta(longint'(new_lat) - longint'(prev_lat))};
                    // The accumulators track the exact position, not the clamped one.
                    prev_lat   = new_lat;
                    prev_lon   = new_lon;
                    prev_alt   = new_alt;
                    rec_count++;
                    r.accepted = 1'b1;
                end
            end
            OP_START_REPLAY:
            begin
                if (rec_count != 0)
                begin
                    prev_lat   = base_lat;
                    prev_lon   = base_lon;
                    prev_alt   = base_alt;
                    replay_ptr = 0;
                    r.accepted = 1'b1;
                end
            end
            OP_REPLAY_NEXT:
            begin
                if (replay_ptr < rec_count && replay_ptr < MAX_RECORDS)
                begin
                    word  = rec_mem[replay_ptr];
                    d_lat = word[DELTA_W-1:0];
                    d_lon = word[2*DELTA_W-1:DELTA_W];
                    d_alt = word[3*DELTA_W-1:2*DELTA_W];
                    // Accumulators wrap at their own widths.
                    prev_lat = prev_lat + d_lat;
                    prev_lon = prev_lon + d_lon;
                    prev_alt = prev_alt + d_alt;
                    r.accepted      = 1'b1;
                    r.record_number = RN_W'(replay_ptr);
                    r.lat_out       = {prev_lat, {POS_SHIFT{1'b0}}};
                    r.lon_out       = {prev_lon, {POS_SHIFT{1'b0}}};
                    r.alt_out       = {prev_alt, {HEIGHT_SHIFT{1'b0}}};
                    r.heading_out   = {word[REC_W-1:3*DELTA_W], 1'b0};
                    replay_ptr++;
                end
            end
        endcase
        return r;
    endfunction

    function automatic string show_result(track_result_t r);
        return $sformatf("acc=%0b rec=%0d lat=%0d lon=%0d alt=%0d hdg=%0d",
                         r.accepted, r.record_number, $signed(r.lat_out), $signed(r.lon_out),
                         $signed(r.alt_out), $signed(r.heading_out));
    endfunction

    function automatic void log_failure(string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    function automatic void queue_cmd(op_t op, logic [COORD_W-1:0] lat, lon, alt,
                                      logic [HDG_W-1:0] heading, logic fix, arm, ready);
        track_cmd_t c;
        c.op      = op;
        c.lat     = lat;
        c.lon     = lon;
        c.alt     = alt;
        c.heading = heading;
        c.fix     = fix;
        c.arm     = arm;
        c.ready   = ready;
        cmd_backlog.push_back(c);
        queued_count++;
    endfunction

    function automatic logic [HDG_W-1:0] rand_heading();
        return HDG_W'($urandom_range(360) - 180);
    endfunction

    // Any operation with fully random position fields and flags.
    function automatic void queue_random(op_t op);
        queue_cmd(op, $urandom(), $urandom(), $urandom(), rand_heading(),
                  1'($urandom()), 1'($urandom()), 1'($urandom()));
    endfunction

    // Moves a raw coordinate by a random number of reduced units. Most moves stay inside the
    // delta range, some saturate, and a few jump anywhere so that the accumulators wrap.
    function automatic logic [COORD_W-1:0] walk(logic [COORD_W-1:0] v, int shift);
        int unsigned pick;
        int          move;
        pick = $urandom_range(99);
        if (pick < 5)
            return $urandom();
        move = (pick < 80) ? int'($urandom_range(240)) - 120 : int'($urandom_range(1200)) - 600;
        return v + COORD_W'(move <<< shift) + COORD_W'($urandom_range((1 << shift) - 1));
    endfunction

    // A session: start a log, record a walk, then replay it, sometimes running past its end.
    // Now and then a replay command lands in the middle of the walk, which moves the shared
    // accumulators and therefore the deltas logged next.
    function automatic void queue_track(int samples, int replays);
        logic [COORD_W-1:0] lat;
        logic [COORD_W-1:0] lon;
        logic [COORD_W-1:0] alt;
        lat = $urandom();
        lon = $urandom();
        alt = $urandom();
        if ($urandom_range(9) == 0)
            queue_cmd(OP_START_LOG, lat, lon, alt, rand_heading(),
                      1'($urandom()), 1'($urandom()), 1'($urandom()));
        else
            queue_cmd(OP_START_LOG, lat, lon, alt, rand_heading(), 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < samples; i++)
        begin
            lat = walk(lat, POS_SHIFT);
            lon = walk(lon, POS_SHIFT);
            alt = walk(alt, HEIGHT_SHIFT);
            if ($urandom_range(19) == 0)
                queue_random($urandom_range(1) ? OP_START_REPLAY : OP_REPLAY_NEXT);
            queue_cmd(OP_LOG_SAMPLE, lat, lon, alt, rand_heading(),
                      $urandom_range(15) != 0, $urandom_range(15) != 0, 1'($urandom()));
        end
        queue_random(OP_START_REPLAY);
        for (int i = 0; i < replays; i++)
            queue_random(OP_REPLAY_NEXT);
    endfunction

    // Returns once every queued command has gone out and every result has come back.
    task automatic wait_until_quiet();
        while (sent_count != queued_count || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_log_mode(logic [MODE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        mode_shadow = value;
        @(negedge clk);
    endtask

    // Driver: a transaction is taken at an edge where start is high and busy is low. The model
    // is stepped at that same edge, so expectations line up with acceptance order. A new
    // command is loaded only when the bus is free, and each signal gets one update per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            operation  <= OP_START_LOG;
            lat_in     <= '0;
            lon_in     <= '0;
            alt_in     <= '0;
            heading_in <= '0;
            gps_fix    <= 1'b0;
            armed      <= 1'b0;
            alt_ready  <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_results.push_back(step_track_model(on_bus));
                sent_count++;
            end
            if (!start || !busy)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_cmd   = cmd_backlog.pop_front();
                    on_bus     <= next_cmd;
                    start      <= 1'b1;
                    operation  <= next_cmd.op;
                    lat_in     <= next_cmd.lat;
                    lon_in     <= next_cmd.lon;
                    alt_in     <= next_cmd.alt;
                    heading_in <= next_cmd.heading;
                    gps_fix    <= next_cmd.fix;
                    armed      <= next_cmd.arm;
                    alt_ready  <= next_cmd.ready;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: a result is valid for exactly the one cycle that done is high, and the
    // receiver has no way to stall it, so it is sampled at the edge that ends that cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.accepted      = accepted;
            seen.record_number = record_number;
            seen.lat_out       = lat_out;
            seen.lon_out       = lon_out;
            seen.alt_out       = alt_out;
            seen.heading_out   = heading_out;
            if (due_results.size() == 0)
            begin
                log_failure({"result with nothing pending: ", show_result(seen)});
            end
            else
            begin
                want       = due_results.pop_front();
                bad_fields = "";
                if (seen.accepted !== want.accepted)
                    bad_fields = {bad_fields, " accepted"};
                if (seen.record_number !== want.record_number)
                    bad_fields = {bad_fields, " record_number"};
                if (seen.lat_out !== want.lat_out)
                    bad_fields = {bad_fields, " lat_out"};
                if (seen.lon_out !== want.lon_out)
                    bad_fields = {bad_fields, " lon_out"};
                if (seen.alt_out !== want.alt_out)
                    bad_fields = {bad_fields, " alt_out"};
                if (seen.heading_out !== want.heading_out)
                    bad_fields = {bad_fields, " heading_out"};
                if (bad_fields != "")
                    log_failure($sformatf("field(s)%s: expected %s, got %s", bad_fields,
                                          show_result(want), show_result(seen)));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus sequencing. Each phase fills the backlog, lets it drain completely, and only
    // then touches the mode register, so a write never lands on a transaction in flight.
    initial
    begin
        int unsigned       idle_plan [4];
        logic [MODE_W-1:0] off_modes [3];
        int                goal;
        idle_plan = '{0, 64, 0, 28};
        off_modes = '{MODE_TOP, MODE_NONE, MODE_SPARE};

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The mode resets to a value that disables everything.
        queue_cmd(OP_LOG_SAMPLE, '0, '0, '0, '0, 1'b1, 1'b1, 1'b1);
        wait_until_quiet();
        write_log_mode(MODE_TRACK_LOGGER);

        // Directed: replay with an empty log, refused start and sample, then a sample that
        // goes through without the altitude reference.
        queue_random(OP_START_REPLAY);
        queue_random(OP_REPLAY_NEXT);
        queue_cmd(OP_START_LOG, 32'h1234_5678, 32'h8765_4321, 32'h0000_4000, '0,
                  1'b1, 1'b1, 1'b0);
        queue_cmd(OP_LOG_SAMPLE, 32'h1234_5678, 32'h8765_4321, 32'h0000_4000, '0,
                  1'b0, 1'b1, 1'b1);
        queue_cmd(OP_LOG_SAMPLE, 32'h0000_0FE0, 32'hFFFF_F000, 32'h0000_1000, 9'h0B4,
                  1'b1, 1'b1, 1'b0);
        // Base at the coordinate extremes, then deltas that wrap, saturate and sit exactly
        // on the byte limits, with the heading at both ends of its range.
        queue_cmd(OP_START_LOG, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 9'h14C,
                  1'b1, 1'b1, 1'b1);
        queue_cmd(OP_LOG_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000, 9'h14C,
                  1'b1, 1'b1, 1'b1);
        queue_cmd(OP_LOG_SAMPLE, 32'h8000_0FE0, 32'h7FFF_EFFF, 32'h000F_FFE0, 9'h1FF,
                  1'b1, 1'b1, 1'b1);
        queue_cmd(OP_LOG_SAMPLE, 32'h8000_0FE0, 32'h7FFF_EFFF, 32'h000F_FFE0, 9'h0B4,
                  1'b1, 1'b0, 1'b1);
        queue_cmd(OP_LOG_SAMPLE, 32'h8000_0FE0, 32'h7FFF_EFFF, 32'h000F_FFE0, '0,
                  1'b1, 1'b1, 1'b1);
        // Replay all three records and one more, which must be refused.
        queue_random(OP_START_REPLAY);
        repeat (4) queue_random(OP_REPLAY_NEXT);
        // A failed start still empties the log but leaves the replay pointer alone.
        queue_cmd(OP_START_LOG, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1);
        queue_random(OP_REPLAY_NEXT);
        // Replay between two samples rewinds the accumulators shared with logging.
        queue_cmd(OP_START_LOG, '0, '0, '0, '0, 1'b1, 1'b1, 1'b1);
        queue_cmd(OP_LOG_SAMPLE, 32'h0000_0C80, '0, '0, '0, 1'b1, 1'b1, 1'b1);
        queue_random(OP_START_REPLAY);
        queue_cmd(OP_LOG_SAMPLE, 32'h0000_0C80, '0, '0, '0, 1'b1, 1'b1, 1'b1);
        repeat (2) queue_random(OP_REPLAY_NEXT);
        wait_until_quiet();

        // Random phases under different sender idling. The first one offers more samples than the
        // store can hold and replays far enough to reach the upper half of the record numbers.
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = idle_plan[ph];
            if (ph == 0)
            begin
                queue_track(MAX_RECORDS + 1, 260);
            end
            else
            begin
                goal = queued_count + 90;
                while (queued_count < goal)
                begin
                    if ($urandom_range(9) < 7)
                    begin
                        int n;
                        n = $urandom_range(24, 1);
                        queue_track(n, n + $urandom_range(2));
                    end
                    else
                    begin
                        repeat ($urandom_range(8, 1)) queue_random(op_t'($urandom_range(3)));
                    end
                end
            end
            wait_until_quiet();
            // A short excursion into a disabled mode; the state must survive it untouched.
            if (ph < 3)
            begin
                write_log_mode(off_modes[ph]);
                repeat (10) queue_random(op_t'($urandom_range(3)));
                wait_until_quiet();
                write_log_mode(MODE_TRACK_LOGGER);
            end
        end

        wait_until_quiet();
        repeat (8) @(posedge clk);
        if (due_results.size() != 0)
            log_failure($sformatf("%0d result(s) never arrived", due_results.size()));
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> gps_track_delta_logger.f
rtl/gtdl_pkg.sv
rtl/gtdl_ctrl.sv
rtl/gtdl_datapath.sv
rtl/gps_track_delta_logger.sv
tb/sv/gps_track_delta_logger_test.sv
